>>> rtl/eor_pkg.sv
// Shared types and constants for the ellipse outline rasterizer.
`timescale 1ns / 1ps
package eor_pkg;

	localparam int COORD_BITS  = 16;
	localparam int RADIUS_BITS = 12;
	localparam int STEP_BITS   = RADIUS_BITS + 1;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_HALF
	} alu_op_t;

	typedef struct packed {
		logic                           op;
		logic signed [COORD_BITS-1:0]   center_x;
		logic signed [COORD_BITS-1:0]   center_y;
		logic        [RADIUS_BITS-1:0]  radius_x;
		logic        [RADIUS_BITS-1:0]  radius_y;
	} cmd_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] pixel_x;
		logic signed [COORD_BITS-1:0] pixel_y;
		logic                         last;
		logic                         done_res;
	} pix_t;

endpackage

>>> rtl/eor_alu.sv
// Shared accumulator adder: add, subtract, or halve toward zero.
`timescale 1ns / 1ps
module eor_alu #(
	parameter int ACC_BITS = 40
) (
	input  eor_pkg::alu_op_t      op,
	input  logic [ACC_BITS-1:0]   a,
	input  logic [ACC_BITS-1:0]   b,
	output logic [ACC_BITS-1:0]   y
);

	logic [ACC_BITS-1:0] b_eff;
	logic                cin;
	logic [ACC_BITS-1:0] sum;

	always_comb begin
		case (op)
			eor_pkg::ALU_SUB: begin
				b_eff = ~b;
				cin   = 1'b1;
			end
			eor_pkg::ALU_HALF: begin
				// bias negatives by one so the shift truncates toward zero
				b_eff = '0;
				cin   = a[ACC_BITS-1];
			end
			default: begin
				b_eff = b;
				cin   = 1'b0;
			end
		endcase
	end

	assign sum = a + b_eff + ACC_BITS'(cin);
	assign y   = (op == eor_pkg::ALU_HALF) ? {sum[ACC_BITS-1], sum[ACC_BITS-1:1]} : sum;

endmodule

>>> rtl/ellipse_outline_rasterizer.sv
// Midpoint ellipse outline rasterizer: sequencer around one multiplier and one adder.
// A start beat runs multiplier states MA to ME; a step beat runs its updates among DY1/DY2, X1 to X3
// and Y1 to Y3. Both settle through SET1, the fixup T2 to T7 when region one ends, and SET2.
// Four pixel beats follow, one a cycle while pix_ready allows; an idle-region step emits none.
// cmd_ready rises the cycle after the last pixel loads; the shared adder does one
// accumulator update a cycle. Reset clears the sequencer and sets the region to idle.
`timescale 1ns / 1ps
module ellipse_outline_rasterizer #(
	parameter int ACC_BITS = 40
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  eor_pkg::cmd_t cmd,
	output logic          pix_valid,
	input  logic          pix_ready,
	output eor_pkg::pix_t pix
);

	localparam int RB  = eor_pkg::RADIUS_BITS;
	localparam int SB  = eor_pkg::STEP_BITS;
	localparam int CW  = eor_pkg::COORD_BITS;
	localparam int PW  = 3 * RB;
	localparam int MXW = (ACC_BITS > PW) ? ACC_BITS : PW;

	typedef enum logic [4:0] {
		S_IDLE, S_MA, S_MB, S_MC, S_MD, S_ME,
		S_DY1, S_DY2, S_X1, S_X2, S_X3, S_Y1, S_Y2, S_Y3,
		S_SET1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7, S_SET2, S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		RG_IDLE,
		RG_ONE,
		RG_TWO
	} region_t;

	state_t              state_q;
	region_t             region_q;
	logic                start_q;
	logic [1:0]          k_q;
	logic [CW-1:0]       org_x_q;
	logic [CW-1:0]       org_y_q;
	logic [RB-1:0]       rx_q;
	logic signed [SB-1:0] step_x_q;
	logic signed [SB-1:0] step_y_q;
	logic [2*RB-1:0]     ax_q;
	logic [2*RB-1:0]     by_q;
	logic [PW-1:0]       mul_q;
	logic [ACC_BITS-1:0] dec_q;
	logic [ACC_BITS-1:0] dx_q;
	logic [ACC_BITS-1:0] dy_q;
	logic [ACC_BITS-1:0] tmp_q;

	logic [2*RB-1:0]     mul_a;
	logic [RB-1:0]       mul_b;
	logic [MXW-1:0]      ax_w, ax4_w, by_w, mul_w;
	logic [ACC_BITS-1:0] ax_acc, ax4_acc, by_acc, mul_acc;
	eor_pkg::alu_op_t    alu_op;
	logic [ACC_BITS-1:0] alu_a, alu_b, alu_y;

	logic                cmd_fire;
	logic                pix_free;
	logic                r1_exit;
	logic                y_done;
	logic [CW-1:0]       off_x, off_y;
	logic                neg_x, neg_y;
	eor_pkg::pix_t       pix_next;

	assign ax_w    = MXW'(ax_q);
	assign ax4_w   = MXW'(ax_q >> 2);
	assign by_w    = MXW'(by_q);
	assign mul_w   = MXW'(mul_q);
	assign ax_acc  = ax_w[ACC_BITS-1:0];
	assign ax4_acc = ax4_w[ACC_BITS-1:0];
	assign by_acc  = by_w[ACC_BITS-1:0];
	assign mul_acc = mul_w[ACC_BITS-1:0];

	assign cmd_ready = (state_q == S_IDLE);
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign pix_free  = !pix_valid || pix_ready;
	assign r1_exit   = (region_q == RG_ONE) && !($signed(dx_q) < $signed(dy_q));
	assign y_done    = step_y_q[SB-1] || (step_y_q == '0);

	// multiplier operands: rx*rx, ry*ry, then ax*ry
	always_comb begin
		case (state_q)
			S_MA: begin
				mul_a = (2*RB)'(rx_q);
				mul_b = rx_q;
			end
			S_MB: begin
				mul_a = (2*RB)'(step_y_q[RB-1:0]);
				mul_b = step_y_q[RB-1:0];
			end
			default: begin
				mul_a = ax_q;
				mul_b = step_y_q[RB-1:0];
			end
		endcase
	end

	always_comb begin
		alu_op = eor_pkg::ALU_ADD;
		alu_a  = dec_q;
		alu_b  = '0;
		case (state_q)
			S_MD: begin
				alu_op = eor_pkg::ALU_SUB;
				alu_a  = by_acc;
				alu_b  = mul_acc;
			end
			S_ME:  alu_b = ax4_acc;
			S_DY1, S_Y1: begin
				alu_op = eor_pkg::ALU_SUB;
				alu_a  = dy_q;
				alu_b  = ax_acc << 1;
			end
			S_DY2, S_Y3: begin
				alu_op = eor_pkg::ALU_SUB;
				alu_b  = dy_q;
			end
			S_X1: begin
				alu_a = dx_q;
				alu_b = by_acc << 1;
			end
			S_X2:  alu_b = by_acc;
			S_X3:  alu_b = dx_q;
			S_Y2:  alu_b = ax_acc;
			S_SET1: begin
				alu_op = eor_pkg::ALU_SUB;
				alu_a  = ax_acc;
				alu_b  = by_acc;
			end
			S_T2: begin
				alu_a = tmp_q;
				alu_b = tmp_q << 1;
			end
			S_T3, S_T6: begin
				alu_op = eor_pkg::ALU_HALF;
				alu_a  = tmp_q;
			end
			S_T4: begin
				alu_op = eor_pkg::ALU_SUB;
				alu_a  = tmp_q;
				alu_b  = dx_q;
			end
			S_T5: begin
				alu_op = eor_pkg::ALU_SUB;
				alu_a  = tmp_q;
				alu_b  = dy_q;
			end
			S_T7:  alu_b = tmp_q;
			default: begin
				alu_op = eor_pkg::ALU_ADD;
			end
		endcase
	end

	eor_alu #(
		.ACC_BITS(ACC_BITS)
	) u_alu (
		.op(alu_op),
		.a (alu_a),
		.b (alu_b),
		.y (alu_y)
	);

	// axis pixels on start, mirrored quadrants on a step
	always_comb begin
		if (start_q) begin
			off_x = k_q[1] ? CW'(rx_q) : '0;
			off_y = k_q[1] ? '0 : CW'(step_y_q);
			neg_x = (k_q == 2'd2);
			neg_y = (k_q == 2'd0);
		end else begin
			off_x = CW'(step_x_q);
			off_y = CW'(step_y_q);
			neg_x = k_q[0];
			neg_y = k_q[1];
		end
		pix_next.pixel_x  = neg_x ? org_x_q - off_x : org_x_q + off_x;
		pix_next.pixel_y  = neg_y ? org_y_q - off_y : org_y_q + off_y;
		pix_next.last     = (k_q == 2'd3);
		pix_next.done_res = (k_q == 2'd3) && (region_q == RG_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			region_q  <= RG_IDLE;
			start_q   <= 1'b0;
			k_q       <= '0;
			pix_valid <= 1'b0;
			pix       <= '0;
			rx_q      <= '0;
			mul_q     <= '0;
			tmp_q     <= '0;
			step_x_q  <= '0;
			step_y_q  <= '0;
			dec_q     <= '0;
			dx_q      <= '0;
			dy_q      <= '0;
			ax_q      <= '0;
			by_q      <= '0;
			org_x_q   <= '0;
			org_y_q   <= '0;
		end else begin
			mul_q <= mul_a * mul_b;
			if (state_q == S_EMIT && pix_free) begin
				pix_valid <= 1'b1;
			end else if (pix_ready) begin
				pix_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						if (cmd.op == eor_pkg::OP_START) begin
							org_x_q  <= cmd.center_x;
							org_y_q  <= cmd.center_y;
							rx_q     <= cmd.radius_x;
							step_x_q <= '0;
							step_y_q <= SB'(cmd.radius_y);
							dx_q     <= '0;
							start_q  <= 1'b1;
							state_q  <= S_MA;
						end else if (region_q == RG_ONE) begin
							start_q <= 1'b0;
							state_q <= ($signed(dec_q) > 0) ? S_DY1 : S_X1;
						end else if (region_q == RG_TWO) begin
							start_q <= 1'b0;
							state_q <= dec_q[ACC_BITS-1] ? S_X1 : S_Y1;
						end
					end
				end
				S_MA: state_q <= S_MB;
				S_MB: begin
					ax_q    <= mul_q[2*RB-1:0];
					state_q <= S_MC;
				end
				S_MC: begin
					by_q    <= mul_q[2*RB-1:0];
					state_q <= S_MD;
				end
				S_MD: begin
					dy_q    <= mul_acc << 1;
					dec_q   <= alu_y;
					state_q <= S_ME;
				end
				S_ME: begin
					dec_q    <= alu_y;
					region_q <= RG_ONE;
					state_q  <= S_SET1;
				end
				S_DY1: begin
					dy_q     <= alu_y;
					step_y_q <= step_y_q - SB'(1);
					state_q  <= S_DY2;
				end
				S_DY2: begin
					dec_q   <= alu_y;
					state_q <= S_X1;
				end
				S_X1: begin
					dx_q     <= alu_y;
					step_x_q <= step_x_q + SB'(1);
					state_q  <= S_X2;
				end
				S_X2: begin
					dec_q   <= alu_y;
					state_q <= S_X3;
				end
				S_X3: begin
					dec_q   <= alu_y;
					state_q <= (region_q == RG_ONE) ? S_SET1 : S_Y1;
				end
				S_Y1: begin
					dy_q     <= alu_y;
					step_y_q <= step_y_q - SB'(1);
					state_q  <= S_Y2;
				end
				S_Y2: begin
					dec_q   <= alu_y;
					state_q <= S_Y3;
				end
				S_Y3: begin
					dec_q   <= alu_y;
					state_q <= S_SET1;
				end
				S_SET1: begin
					// region one ends once dx catches dy: one-time decision fixup
					if (r1_exit) begin
						tmp_q   <= alu_y;
						state_q <= S_T2;
					end else begin
						state_q <= S_SET2;
					end
				end
				S_T2: begin
					tmp_q   <= alu_y;
					state_q <= S_T3;
				end
				S_T3: begin
					tmp_q   <= alu_y;
					state_q <= S_T4;
				end
				S_T4: begin
					tmp_q   <= alu_y;
					state_q <= S_T5;
				end
				S_T5: begin
					tmp_q   <= alu_y;
					state_q <= S_T6;
				end
				S_T6: begin
					tmp_q   <= alu_y;
					state_q <= S_T7;
				end
				S_T7: begin
					dec_q    <= alu_y;
					region_q <= RG_TWO;
					state_q  <= S_SET2;
				end
				S_SET2: begin
					if (region_q == RG_TWO && y_done) begin
						region_q <= RG_IDLE;
					end
					k_q     <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (pix_free) begin
						pix <= pix_next;
						k_q <= k_q + 2'd1;
						if (k_q == 2'd3) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/eor_checker.sv
// Port-level checks for the ellipse outline rasterizer, bound to the top level.
`timescale 1ns / 1ps
module eor_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_ready,
	input eor_pkg::cmd_t cmd,
	input logic          pix_valid,
	input logic          pix_ready,
	input eor_pkg::pix_t pix
);

	// a stalled pixel beat holds
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(pix))
		else $error("pixel beat changed while stalled");

	// a start always produces pixels, so the block goes busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd.op == eor_pkg::OP_START |=> !cmd_ready)
		else $error("ready after start beat");

	// the ellipse ends only on the final pixel of an item
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix.done_res |-> pix.last)
		else $error("done without last");

	// while an item still owes pixels, no new command is taken
	a_busy_midburst: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix.last |-> !cmd_ready)
		else $error("ready in the middle of a pixel burst");

endmodule

bind ellipse_outline_rasterizer eor_checker u_eor_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd_valid),
	.cmd_ready(cmd_ready),
	.cmd      (cmd),
	.pix_valid(pix_valid),
	.pix_ready(pix_ready),
	.pix      (pix)
);

>>> test/tb_top.sv
// Self-checking testbench for the midpoint ellipse outline rasterizer.
`timescale 1ns / 1ps
module tb_top;

	localparam int ACC_W      = 40;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_WAIT = 40;

	typedef enum logic [1:0] {
		RG_IDLE,
		RG_ONE,
		RG_TWO
	} rgn_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	eor_pkg::cmd_t cmd = '0;
	logic pix_valid;
	logic pix_ready = 1'b0;
	eor_pkg::pix_t pix;

	ellipse_outline_rasterizer #(.ACC_BITS(ACC_W)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix      (pix)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted rasterizer state
	rgn_t        cur_rgn = RG_IDLE;
	longint      off_x = 0, off_y = 0;
	longint      err_term = 0, grad_x = 0, grad_y = 0;
	longint      rx2 = 0, ry2 = 0;
	logic [15:0] ctr_x = '0, ctr_y = '0;

	eor_pkg::pix_t pending_pixels[$];
	int unsigned fails = 0;
	int unsigned beats_sent = 0;
	bit          cmd_calm = 1'b0, pix_calm = 1'b0;

	function automatic longint acc_fold(longint v);
		logic signed [ACC_W-1:0] t;
		t = v[ACC_W-1:0];
		return longint'(t);
	endfunction

	// k bit 0 mirrors x, bit 1 mirrors y
	function automatic eor_pkg::pix_t mirror_pixel(int k);
		eor_pkg::pix_t p;
		logic [15:0]   dx, dy;
		dx = off_x[15:0];
		dy = off_y[15:0];
		p.pixel_x  = k[0] ? ctr_x - dx : ctr_x + dx;
		p.pixel_y  = k[1] ? ctr_y - dy : ctr_y + dy;
		p.last     = 1'b0;
		p.done_res = 1'b0;
		return p;
	endfunction

	function automatic void step_right();
		off_x++;
		grad_x   = acc_fold(grad_x + 2 * ry2);
		err_term = acc_fold(err_term + ry2 + grad_x);
	endfunction

	function automatic void predict_pixels(eor_pkg::cmd_t c);
		eor_pkg::pix_t quad[4];
		longint        rx, ry, t, s, u;
		if (c.op == eor_pkg::OP_START) begin
			rx       = longint'(c.radius_x);
			ry       = longint'(c.radius_y);
			ctr_x    = c.center_x;
			ctr_y    = c.center_y;
			rx2      = rx * rx;
			ry2      = ry * ry;
			off_x    = 0;
			off_y    = ry;
			err_term = acc_fold(ry2 - rx2 * ry + rx2 / 4);
			grad_x   = 0;
			grad_y   = acc_fold(2 * rx2 * ry);
			foreach (quad[k]) begin
				quad[k] = '0;
			end
			quad[0].pixel_x = ctr_x;
			quad[0].pixel_y = ctr_y - ry[15:0];
			quad[1].pixel_x = ctr_x;
			quad[1].pixel_y = ctr_y + ry[15:0];
			quad[2].pixel_x = ctr_x - rx[15:0];
			quad[2].pixel_y = ctr_y;
			quad[3].pixel_x = ctr_x + rx[15:0];
			quad[3].pixel_y = ctr_y;
			cur_rgn = RG_ONE;
		end else if (cur_rgn == RG_ONE) begin
			if (err_term > 0) begin
				off_y--;
				grad_y   = acc_fold(grad_y - 2 * rx2);
				err_term = acc_fold(err_term - grad_y);
			end
			step_right();
		end else if (cur_rgn == RG_TWO) begin
			if (err_term < 0)
				step_right();
			off_y--;
			grad_y   = acc_fold(grad_y - 2 * rx2);
			err_term = acc_fold(err_term + rx2 - grad_y);
		end else begin
			return;
		end
		if (c.op == eor_pkg::OP_STEP) begin
			foreach (quad[k]) begin
				quad[k] = mirror_pixel(k);
			end
		end
		// skip phases with no iteration left; halvings truncate toward zero
		if (cur_rgn == RG_ONE && !(grad_x < grad_y)) begin
			t        = acc_fold(3 * (rx2 - ry2));
			s        = acc_fold(grad_x + grad_y);
			u        = acc_fold(t / 2 - s);
			err_term = acc_fold(err_term + u / 2);
			cur_rgn  = RG_TWO;
		end
		if (cur_rgn == RG_TWO && !(off_y > 0))
			cur_rgn = RG_IDLE;
		quad[3].last     = 1'b1;
		quad[3].done_res = (cur_rgn == RG_IDLE);
		foreach (quad[k]) begin
			pending_pixels.push_back(quad[k]);
		end
	endfunction

	function automatic int unsigned idle_draw(bit calm);
		return calm ? 0 : $urandom_range(0, 18);
	endfunction

	// entered and left at a falling edge
	task automatic send_beat(eor_pkg::cmd_t c);
		int unsigned gap;
		if ($urandom_range(0, 39) == 0)
			cmd_calm = !cmd_calm;
		gap = idle_draw(cmd_calm);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
		predict_pixels(c);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_start(logic [15:0] x, logic [15:0] y, logic [11:0] rx,
			logic [11:0] ry);
		eor_pkg::cmd_t c;
		c.op       = eor_pkg::OP_START;
		c.center_x = x;
		c.center_y = y;
		c.radius_x = rx;
		c.radius_y = ry;
		send_beat(c);
	endtask

	// payload of a step is ignored, so it is random
	task automatic send_step();
		eor_pkg::cmd_t c;
		c.op       = eor_pkg::OP_STEP;
		c.center_x = 16'($urandom_range(0, 65535));
		c.center_y = 16'($urandom_range(0, 65535));
		c.radius_x = 12'($urandom_range(0, 4095));
		c.radius_y = 12'($urandom_range(0, 4095));
		send_beat(c);
	endtask

	task automatic finish_ellipse(int unsigned cap);
		int unsigned n;
		n = 0;
		while (cur_rgn != RG_IDLE && n < cap) begin
			send_step();
			n++;
		end
	endtask

	task automatic test_idle_steps();
		eor_pkg::cmd_t c;
		c = '1;
		send_beat(c);
		send_step();
	endtask

	task automatic test_zero_radius();
		send_start(16'h7fff, 16'h8000, 12'd4095, 12'd0);
		send_step();
		send_start(16'hffff, 16'd100, 12'd0, 12'd3);
		finish_ellipse(20);
		send_start(16'h0000, 16'h0000, 12'd0, 12'd0);
	endtask

	task automatic test_small_wrapping();
		send_start(16'h7ffe, 16'h8001, 12'd3, 12'd2);
		finish_ellipse(20);
	endtask

	task automatic test_restart();
		send_start(16'h8000, 16'h7fff, 12'd4095, 12'd4095);
		send_step();
		send_step();
		send_start(16'd5, 16'hfffb, 12'd1, 12'd1);
		finish_ellipse(20);
		send_step();
	endtask

	task automatic test_random_traffic(int unsigned count);
		int unsigned   target, sz, rx, ry;
		eor_pkg::cmd_t c;
		target = beats_sent + count;
		while (beats_sent < target) begin
			if ($urandom_range(0, 99) < 80) begin
				sz = $urandom_range(0, 19);
				if (sz < 14) begin
					rx = $urandom_range(0, 12);
					ry = $urandom_range(0, 12);
				end else if (sz < 17) begin
					rx = $urandom_range(0, 40);
					ry = $urandom_range(0, 40);
				end else begin
					rx = $urandom_range(0, 4095);
					ry = $urandom_range(0, 4095);
				end
				send_start(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
					12'(rx), 12'(ry));
				if (sz >= 17)
					repeat ($urandom_range(1, 6)) send_step();
				else if ($urandom_range(0, 6) == 0)
					repeat ($urandom_range(1, 8)) send_step();
				else
					finish_ellipse(300);
				if ($urandom_range(0, 3) == 0)
					send_step();
			end else begin
				c.op       = 1'($urandom_range(0, 1));
				c.center_x = 16'($urandom_range(0, 65535));
				c.center_y = 16'($urandom_range(0, 65535));
				c.radius_x = 12'($urandom_range(0, 4095));
				c.radius_y = 12'($urandom_range(0, 4095));
				send_beat(c);
			end
		end
	endtask

	initial begin : pix_sink
		int unsigned hold;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 39) == 0)
				pix_calm = !pix_calm;
			hold = idle_draw(pix_calm);
			if (hold > 0) begin
				pix_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			pix_ready <= 1'b1;
			do @(posedge clk); while (!pix_valid);
		end
	end

	always @(posedge clk) begin : pix_check
		eor_pkg::pix_t want;
		if (arst_n && pix_valid && pix_ready) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected pixel beat x=%0d y=%0d", pix.pixel_x, pix.pixel_y);
				fails++;
			end else begin
				want = pending_pixels.pop_front();
				if (pix.pixel_x !== want.pixel_x) begin
					$error("pixel_x: expected %0d, got %0d", want.pixel_x, pix.pixel_x);
					fails++;
				end
				if (pix.pixel_y !== want.pixel_y) begin
					$error("pixel_y: expected %0d, got %0d", want.pixel_y, pix.pixel_y);
					fails++;
				end
				if (pix.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, pix.last);
					fails++;
				end
				if (pix.done_res !== want.done_res) begin
					$error("done_res: expected %0b, got %0b", want.done_res, pix.done_res);
					fails++;
				end
			end
		end
	end

	// stall watchdog: cycles with no beat on either channel
	always @(posedge clk) begin : stall_watch
		int unsigned quiet;
		if ((cmd_valid && cmd_ready) || (pix_valid && pix_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_idle_steps();
		test_zero_radius();
		test_small_wrapping();
		test_restart();
		test_random_traffic(350);
		cmd_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
